### src/keyed_running_stats_anomaly_defines.svh
// ----------------------------------------------------------------------------
// keyed_running_stats_anomaly_defines.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef KEYED_RUNNING_STATS_ANOMALY_DEFINES_SVH
`define KEYED_RUNNING_STATS_ANOMALY_DEFINES_SVH

// same-cycle implication
`define KRSA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("krsa check failed");

// next-cycle implication
`define KRSA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("krsa check failed");

`endif

### src/krsa_pkg.sv
// ----------------------------------------------------------------------------
// krsa_pkg
// types and constants of the keyed running statistics block
// ----------------------------------------------------------------------------
package krsa_pkg;

    localparam int CPU_BITS       = 7;
    localparam int RSS_BITS       = 32;
    localparam int COUNT_BITS     = 16;
    localparam int SIGMA_BITS     = 8;
    localparam int MEAN_OUT_BITS  = 15;
    localparam int MAX_KEY_BITS   = 64;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CPU_BITS-1:0]   CPU_MAX           = 7'd100;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX         = 16'hFFFF;
    localparam logic [SIGMA_BITS-1:0] SIGMA_RESET       = 8'd48;
    localparam logic [COUNT_BITS-1:0] MIN_SAMPLES_RESET = 16'd5;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SIGMA       = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_SAMPLES = 2'd1;

    typedef struct packed {
        logic [MAX_KEY_BITS-1:0] key;
        logic [CPU_BITS-1:0]     cpu;
        logic [RSS_BITS-1:0]     rss;
        logic                    upd;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        logic [SIGMA_BITS-1:0] sigma;
        logic [COUNT_BITS-1:0] min_samples;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_ctrl_t;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_KRD,
        BS_KCMP,
        BS_DECIDE,
        BS_RRD,
        BS_RLOAD,
        BS_OP,
        BS_WAIT,
        BS_WRITE,
        BS_CHECK
    } back_state_t;

    typedef enum logic [2:0] {
        STEP_DIVQ,
        STEP_MULP,
        STEP_MULS,
        STEP_MULN,
        STEP_DIVV,
        STEP_SQRT
    } step_t;

    typedef struct packed {
        logic                     found;
        logic                     full;
        logic                     cpu_anom;
        logic                     rss_anom;
        logic [MEAN_OUT_BITS-1:0] mean_cpu;
        logic [COUNT_BITS-1:0]    count;
        logic [CPU_BITS-1:0]      peak_cpu;
        logic [RSS_BITS-1:0]      peak_rss;
    } result_t;

endpackage

### src/krsa_front.sv
// ----------------------------------------------------------------------------
// krsa_front
// command intake: clamps and masks each word and holds it in a two-deep queue
// ----------------------------------------------------------------------------
module krsa_front import krsa_pkg::*; #(
    parameter int KEY_BITS = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [MAX_KEY_BITS-1:0] name_key,
    input  logic [CPU_BITS-1:0]     cpu_percent,
    input  logic [RSS_BITS-1:0]     rss_kilobytes,
    input  logic                    update_enable,
    output logic                    busy,
    output queue_head_t             head,
    input  logic                    pop
);

    item_t      q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    item_t      in_item;

    assign busy = (count_reg == 2'd2);
    assign push = start && !busy;

    always_comb
    begin
        in_item.key = MAX_KEY_BITS'(name_key[KEY_BITS-1:0]);
        in_item.cpu = (cpu_percent > CPU_MAX) ? CPU_MAX : cpu_percent;
        in_item.rss = rss_kilobytes;
        in_item.upd = update_enable;
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= in_item;
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = q_mem[rd_ptr_reg];

endmodule

### src/krsa_arith.sv
// ----------------------------------------------------------------------------
// krsa_arith
// shared serial unit: shift-add multiply, restoring divide, digit-by-digit
// square root, one bit (or one root digit) per cycle
// ----------------------------------------------------------------------------
module krsa_arith import krsa_pkg::*; #(
    parameter int W  = 40,
    parameter int AW = 2 * W + COUNT_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  arith_ctrl_t   ctrl,
    input  logic [AW-1:0] opa,
    input  logic [W-1:0]  opb,
    output logic [AW-1:0] result,
    output logic          done
);

    localparam int CW = $clog2(AW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    arith_op_t     op_reg, op_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [AW-1:0] a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W+1:0]  rem_reg, rem_next;
    logic [W-1:0]  root_reg, root_next;

    logic [COUNT_BITS:0] div_num;
    logic [COUNT_BITS:0] div_d;
    logic [W+1:0]        sq_num;
    logic [W+1:0]        sq_trial;

    always_comb
    begin
        div_num  = {rem_reg[COUNT_BITS-1:0], acc_reg[AW-1]};
        div_d    = {1'b0, b_reg[COUNT_BITS-1:0]};
        sq_num   = {rem_reg[W-1:0], acc_reg[AW-1:AW-2]};
        sq_trial = {root_reg, 2'b01};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            op_next   = ctrl.op;
            a_next    = opa;
            b_next    = opb;
            rem_next  = '0;
            root_next = '0;
            unique case (ctrl.op)
                OP_MUL:
                begin
                    cnt_next = CW'(W);
                    acc_next = '0;
                end
                OP_DIV:
                begin
                    cnt_next = CW'(AW);
                    acc_next = opa;
                end
                default:
                begin
                    // radicand sits in the low 2W bits, align it to the top
                    cnt_next = CW'(W);
                    acc_next = opa << (AW - 2 * W);
                end
            endcase
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            unique case (op_reg)
                OP_MUL:
                begin
                    acc_next = (acc_reg << 1) + (b_reg[W-1] ? a_reg : '0);
                    b_next   = b_reg << 1;
                end
                OP_DIV:
                begin
                    if (div_num >= div_d)
                    begin
                        rem_next = (W+2)'(div_num - div_d);
                        acc_next = {acc_reg[AW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = (W+2)'(div_num);
                        acc_next = {acc_reg[AW-2:0], 1'b0};
                    end
                end
                default:
                begin
                    acc_next = acc_reg << 2;
                    if (sq_num >= sq_trial)
                    begin
                        rem_next  = sq_num - sq_trial;
                        root_next = {root_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next  = sq_num;
                        root_next = {root_reg[W-2:0], 1'b0};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign result = (op_reg == OP_SQRT) ? AW'(root_reg) : acc_reg;
    assign done   = done_reg;

endmodule

### src/krsa_back.sv
// ----------------------------------------------------------------------------
// krsa_back
// execution side: key search, Welford update through the shared serial unit,
// table write back and anomaly check
// ----------------------------------------------------------------------------
module krsa_back import krsa_pkg::*; #(
    parameter int TABLE_ENTRIES = 128,
    parameter int KEY_BITS      = 64,
    parameter int FRAC_BITS     = 8,
    parameter int W             = RSS_BITS + FRAC_BITS,
    parameter int AW            = 2 * W + COUNT_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  queue_head_t   head,
    output logic          pop,
    input  cfg_t          cfg,
    output arith_ctrl_t   arith_ctrl,
    output logic [AW-1:0] arith_a,
    output logic [W-1:0]  arith_b,
    input  logic [AW-1:0] arith_res,
    input  logic          arith_done,
    output logic          done,
    output result_t       result
);

    localparam int IW   = $clog2(TABLE_ENTRIES);
    localparam int UW   = $clog2(TABLE_ENTRIES + 1);
    localparam int CMW  = CPU_BITS + FRAC_BITS;
    localparam int RECW = COUNT_BITS + 2 * CMW + 2 * W + CPU_BITS + RSS_BITS;
    localparam int TW   = W + SIGMA_BITS + 1;

    logic [KEY_BITS-1:0] key_mem [TABLE_ENTRIES];
    logic [RECW-1:0]     rec_mem [TABLE_ENTRIES];
    logic [KEY_BITS-1:0] key_q;
    logic [RECW-1:0]     rec_q;

    back_state_t state_reg, state_next;
    step_t       step_reg;
    logic        ch_reg;
    item_t       item_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] slot_reg;
    logic [UW-1:0] used_reg;
    logic        found_reg;
    logic        full_reg;
    logic        done_reg;
    result_t     res_reg;

    logic [COUNT_BITS-1:0] cnt_reg;
    logic [W-1:0]          cm_reg, cd_reg, rm_reg, rd_reg;
    logic [CPU_BITS-1:0]   pc_reg;
    logic [RSS_BITS-1:0]   pr_reg;
    logic [W-1:0]          x_reg, m_reg, dv_reg, d_reg, e_reg;
    logic                  neg_reg;
    logic [AW-1:0]         p_reg, a_reg;

    logic [COUNT_BITS-1:0] u_cnt;
    logic [CMW-1:0]        u_cm, u_cd;
    logic [W-1:0]          u_rm, u_rd;
    logic [CPU_BITS-1:0]   u_pc;
    logic [RSS_BITS-1:0]   u_pr;

    logic          key_we, rec_we;
    logic          key_hit, search_end, has_room;
    logic [W-1:0]  d_w, q_w, nm_w, e_w;
    logic [W-1:0]  cpu_xq, rss_xq;
    logic          stats_ready;
    logic [TW-1:0] cpu_lhs, cpu_rhs, rss_lhs, rss_rhs;
    logic [W+SIGMA_BITS-1:0] cpu_prod, rss_prod;

    assign {u_cnt, u_cm, u_cd, u_rm, u_rd, u_pc, u_pr} = rec_q;

    assign key_hit    = (key_q == item_reg.key[KEY_BITS-1:0]);
    assign search_end = ((UW'(idx_reg) + UW'(1)) == used_reg);
    assign has_room   = (used_reg < UW'(TABLE_ENTRIES));

    assign cpu_xq = W'(item_reg.cpu) << FRAC_BITS;
    assign rss_xq = W'(item_reg.rss) << FRAC_BITS;

    // welford mean step, sign of the deviation kept apart
    always_comb
    begin
        d_w  = (x_reg >= m_reg) ? (x_reg - m_reg) : (m_reg - x_reg);
        q_w  = arith_res[W-1:0];
        nm_w = neg_reg ? (m_reg - q_w) : (m_reg + q_w);
        e_w  = neg_reg ? (nm_w - x_reg) : (x_reg - nm_w);
    end

    always_comb
    begin
        stats_ready = (cnt_reg >= cfg.min_samples);
        cpu_prod    = (W+SIGMA_BITS)'(cfg.sigma) * (W+SIGMA_BITS)'(cd_reg);
        rss_prod    = (W+SIGMA_BITS)'(cfg.sigma) * (W+SIGMA_BITS)'(rd_reg);
        cpu_lhs     = TW'(cpu_xq) << 4;
        rss_lhs     = TW'(rss_xq) << 4;
        cpu_rhs     = (TW'(cm_reg) << 4) + TW'(cpu_prod);
        rss_rhs     = (TW'(rm_reg) << 4) + TW'(rss_prod);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE:
                if (head.valid)
                    state_next = (used_reg == '0) ? BS_DECIDE : BS_KRD;
            BS_KRD:
                state_next = BS_KCMP;
            BS_KCMP:
                if (key_hit || search_end)
                    state_next = BS_DECIDE;
                else
                    state_next = BS_KRD;
            BS_DECIDE:
                if (found_reg)
                    state_next = BS_RRD;
                else if (item_reg.upd && has_room)
                    state_next = BS_WRITE;
                else
                    state_next = BS_CHECK;
            BS_RRD:
                state_next = BS_RLOAD;
            BS_RLOAD:
                state_next = item_reg.upd ? BS_OP : BS_CHECK;
            BS_OP:
                state_next = BS_WAIT;
            BS_WAIT:
                if (arith_done)
                begin
                    if (step_reg == STEP_SQRT && ch_reg)
                        state_next = BS_WRITE;
                    else
                        state_next = BS_OP;
                end
            BS_WRITE:
                state_next = BS_CHECK;
            BS_CHECK:
                state_next = BS_IDLE;
            default:
                state_next = BS_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop              = (state_reg == BS_IDLE) && head.valid;
        key_we           = (state_reg == BS_WRITE);
        rec_we           = (state_reg == BS_WRITE);
        arith_ctrl.start = (state_reg == BS_OP);
        arith_ctrl.op    = OP_MUL;
        arith_a          = '0;
        arith_b          = '0;
        unique case (step_reg)
            STEP_DIVQ:
            begin
                arith_ctrl.op = OP_DIV;
                arith_a       = AW'(d_w);
                arith_b       = W'(cnt_reg);
            end
            STEP_MULP:
            begin
                arith_a = AW'(d_reg);
                arith_b = e_reg;
            end
            STEP_MULS:
            begin
                arith_a = AW'(dv_reg);
                arith_b = dv_reg;
            end
            STEP_MULN:
            begin
                arith_a = a_reg;
                arith_b = W'(cnt_reg - COUNT_BITS'(1));
            end
            STEP_DIVV:
            begin
                arith_ctrl.op = OP_DIV;
                arith_a       = a_reg;
                arith_b       = W'(cnt_reg);
            end
            default:
            begin
                arith_ctrl.op = OP_SQRT;
                arith_a       = a_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_IDLE;
            step_reg  <= STEP_DIVQ;
            ch_reg    <= 1'b0;
            used_reg  <= '0;
            found_reg <= 1'b0;
            full_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == BS_CHECK);
            unique case (state_reg)
                BS_IDLE:
                begin
                    found_reg <= 1'b0;
                    full_reg  <= 1'b0;
                end
                BS_KCMP:
                    if (key_hit)
                        found_reg <= 1'b1;
                BS_DECIDE:
                    if (!found_reg && item_reg.upd)
                    begin
                        if (has_room)
                        begin
                            found_reg <= 1'b1;
                            used_reg  <= used_reg + UW'(1);
                        end
                        else
                            full_reg <= 1'b1;
                    end
                BS_RLOAD:
                begin
                    step_reg <= STEP_DIVQ;
                    ch_reg   <= 1'b0;
                end
                BS_WAIT:
                    if (arith_done)
                    begin
                        unique case (step_reg)
                            STEP_DIVQ: step_reg <= STEP_MULP;
                            STEP_MULP: step_reg <= STEP_MULS;
                            STEP_MULS: step_reg <= STEP_MULN;
                            STEP_MULN: step_reg <= STEP_DIVV;
                            STEP_DIVV: step_reg <= STEP_SQRT;
                            default:
                            begin
                                step_reg <= STEP_DIVQ;
                                ch_reg   <= 1'b1;
                            end
                        endcase
                    end
                default:
                begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BS_IDLE:
            begin
                item_reg <= head.item;
                idx_reg  <= '0;
            end
            BS_KCMP:
                if (key_hit)
                    slot_reg <= idx_reg;
                else
                    idx_reg <= idx_reg + IW'(1);
            BS_DECIDE:
                if (!found_reg)
                begin
                    slot_reg <= used_reg[IW-1:0];
                    cnt_reg  <= COUNT_BITS'(1);
                    cm_reg   <= cpu_xq;
                    cd_reg   <= '0;
                    rm_reg   <= rss_xq;
                    rd_reg   <= '0;
                    pc_reg   <= item_reg.cpu;
                    pr_reg   <= item_reg.rss;
                end
            BS_RLOAD:
            begin
                cm_reg <= W'(u_cm);
                cd_reg <= W'(u_cd);
                rm_reg <= u_rm;
                rd_reg <= u_rd;
                x_reg  <= cpu_xq;
                m_reg  <= W'(u_cm);
                dv_reg <= W'(u_cd);
                if (item_reg.upd)
                begin
                    cnt_reg <= (u_cnt == COUNT_MAX) ? u_cnt : (u_cnt + COUNT_BITS'(1));
                    pc_reg  <= (item_reg.cpu > u_pc) ? item_reg.cpu : u_pc;
                    pr_reg  <= (item_reg.rss > u_pr) ? item_reg.rss : u_pr;
                end
                else
                begin
                    cnt_reg <= u_cnt;
                    pc_reg  <= u_pc;
                    pr_reg  <= u_pr;
                end
            end
            BS_OP:
                if (step_reg == STEP_DIVQ)
                begin
                    d_reg   <= d_w;
                    neg_reg <= (x_reg < m_reg);
                end
            BS_WAIT:
                if (arith_done)
                begin
                    unique case (step_reg)
                        STEP_DIVQ:
                        begin
                            m_reg <= nm_w;
                            e_reg <= e_w;
                        end
                        STEP_MULP: p_reg <= arith_res;
                        STEP_MULS: a_reg <= arith_res;
                        STEP_MULN: a_reg <= arith_res + p_reg;
                        STEP_DIVV: a_reg <= arith_res;
                        default:
                        begin
                            if (!ch_reg)
                            begin
                                cm_reg <= m_reg;
                                cd_reg <= arith_res[W-1:0];
                                // switch over to the memory channel
                                x_reg  <= rss_xq;
                                m_reg  <= rm_reg;
                                dv_reg <= rd_reg;
                            end
                            else
                            begin
                                rm_reg <= m_reg;
                                rd_reg <= arith_res[W-1:0];
                            end
                        end
                    endcase
                end
            BS_CHECK:
            begin
                res_reg.full <= full_reg;
                if (found_reg)
                begin
                    res_reg.found    <= 1'b1;
                    res_reg.cpu_anom <= stats_ready && (cpu_lhs > cpu_rhs);
                    res_reg.rss_anom <= stats_ready && (rss_lhs > rss_rhs);
                    res_reg.mean_cpu <= cm_reg[MEAN_OUT_BITS-1:0];
                    res_reg.count    <= cnt_reg;
                    res_reg.peak_cpu <= pc_reg;
                    res_reg.peak_rss <= pr_reg;
                end
                else
                begin
                    res_reg.found    <= 1'b0;
                    res_reg.cpu_anom <= 1'b0;
                    res_reg.rss_anom <= 1'b0;
                    res_reg.mean_cpu <= '0;
                    res_reg.count    <= '0;
                    res_reg.peak_cpu <= '0;
                    res_reg.peak_rss <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[slot_reg] <= item_reg.key[KEY_BITS-1:0];
        key_q <= key_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
            rec_mem[slot_reg] <= {cnt_reg, cm_reg[CMW-1:0], cd_reg[CMW-1:0], rm_reg, rd_reg,
                                  pc_reg, pr_reg};
        rec_q <= rec_mem[slot_reg];
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

### src/keyed_running_stats_anomaly.sv
// ----------------------------------------------------------------------------
// keyed_running_stats_anomaly
// keyed table of running mean and deviation of cpu share and memory size,
// with threshold anomaly flags
// ----------------------------------------------------------------------------
// channel  | handshake                  | payload
// command  | start in, busy out         | name_key, cpu_percent, rss_kilobytes,
//          |                            | update_enable
// result   | done out, one-cycle strobe | entry_found, table_full, cpu_anomaly,
//          |                            | rss_anomaly, cpu_mean_q8, sample_count,
//          |                            | peak_cpu, peak_rss
// config   | cfg_valid in, cfg_ready out| cfg_index, cfg_data
//
// a check-only word is paced by the key search, which reads the table one slot
// at a time through a read state and a compare state
// a learning word adds a pass through the shared serial multiply/divide/sqrt
// unit, one bit per cycle, both channels in turn
// a two-deep command queue takes new words while the back end works; busy is
// high only when it is full. results cannot be stalled
// reset clears control state only; table slots are read only below the fill
// count, so there is no clearing pass
// ----------------------------------------------------------------------------
module keyed_running_stats_anomaly import krsa_pkg::*; #(
    parameter int TABLE_ENTRIES = 128,
    parameter int KEY_BITS      = 64,
    parameter int FRAC_BITS     = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [MAX_KEY_BITS-1:0]   name_key,
    input  logic [CPU_BITS-1:0]       cpu_percent,
    input  logic [RSS_BITS-1:0]       rss_kilobytes,
    input  logic                      update_enable,
    output logic                      done,
    output logic                      entry_found,
    output logic                      table_full,
    output logic                      cpu_anomaly,
    output logic                      rss_anomaly,
    output logic [MEAN_OUT_BITS-1:0]  cpu_mean_q8,
    output logic [COUNT_BITS-1:0]     sample_count,
    output logic [CPU_BITS-1:0]       peak_cpu,
    output logic [RSS_BITS-1:0]       peak_rss,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int W  = RSS_BITS + FRAC_BITS;
    localparam int AW = 2 * W + COUNT_BITS;

    logic [SIGMA_BITS-1:0] sigma_reg;
    logic [COUNT_BITS-1:0] min_samples_reg;
    cfg_t                  cfg;
    queue_head_t           head;
    logic                  pop;
    arith_ctrl_t           arith_ctrl;
    logic [AW-1:0]         arith_a;
    logic [W-1:0]          arith_b;
    logic [AW-1:0]         arith_res;
    logic                  arith_done;
    result_t               result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg       <= SIGMA_RESET;
            min_samples_reg <= MIN_SAMPLES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SIGMA:       sigma_reg       <= cfg_data[SIGMA_BITS-1:0];
                REG_MIN_SAMPLES: min_samples_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.sigma       = sigma_reg;
    assign cfg.min_samples = min_samples_reg;

    krsa_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .name_key      (name_key),
        .cpu_percent   (cpu_percent),
        .rss_kilobytes (rss_kilobytes),
        .update_enable (update_enable),
        .busy          (busy),
        .head          (head),
        .pop           (pop)
    );

    krsa_arith #(
        .W  (W),
        .AW (AW)
    ) u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (arith_ctrl),
        .opa    (arith_a),
        .opb    (arith_b),
        .result (arith_res),
        .done   (arith_done)
    );

    krsa_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS),
        .FRAC_BITS     (FRAC_BITS),
        .W             (W),
        .AW            (AW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .cfg        (cfg),
        .arith_ctrl (arith_ctrl),
        .arith_a    (arith_a),
        .arith_b    (arith_b),
        .arith_res  (arith_res),
        .arith_done (arith_done),
        .done       (done),
        .result     (result)
    );

    assign entry_found  = result.found;
    assign table_full   = result.full;
    assign cpu_anomaly  = result.cpu_anom;
    assign rss_anomaly  = result.rss_anom;
    assign cpu_mean_q8  = result.mean_cpu;
    assign sample_count = result.count;
    assign peak_cpu     = result.peak_cpu;
    assign peak_rss     = result.peak_rss;

endmodule

### src/krsa_checker.sv
// ----------------------------------------------------------------------------
// krsa_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "keyed_running_stats_anomaly_defines.svh"

module krsa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input logic        entry_found,
    input logic        table_full,
    input logic        cpu_anomaly,
    input logic        rss_anomaly,
    input logic [14:0] cpu_mean_q8,
    input logic [15:0] sample_count,
    input logic [6:0]  peak_cpu
);

    // a full table never reports an entry
    `KRSA_ASSERT_IMP(a_full_no_entry, clk, rst_n, done && table_full, !entry_found)

    // a missing entry reports clear anomaly flags and a zero mean and count
    `KRSA_ASSERT_IMP(a_miss_zero, clk, rst_n, done && !entry_found,
        !cpu_anomaly && !rss_anomaly && cpu_mean_q8 == 15'd0 && sample_count == 16'd0)

    // a live entry has seen at least one sample and a clamped cpu peak
    `KRSA_ASSERT_IMP(a_hit_sane, clk, rst_n, done && entry_found,
        sample_count != 16'd0 && peak_cpu <= 7'd100)

    // results never come back to back
    `KRSA_ASSERT_NXT(a_done_spaced, clk, rst_n, done, !done)

endmodule

bind keyed_running_stats_anomaly krsa_checker u_krsa_checker (.*);

### test/tb_keyed_running_stats_anomaly.sv
// ----------------------------------------------------------------------------
// tb_keyed_running_stats_anomaly
// self-checking bench for the keyed running statistics block: a class-based
// scoreboard keeps its own Welford table and predicts every result word,
// while plain tasks drive commands with random gaps and rewrite the
// threshold registers between phases
// ----------------------------------------------------------------------------
module tb_keyed_running_stats_anomaly import krsa_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 128;
    localparam int FRAC = 8;
    localparam int POOL = 200;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

    class stats_scoreboard;
        logic [7:0]  sigma;
        logic [15:0] min_count;
        int          used;
        logic [63:0] key_tab [SLOTS];
        logic [15:0] count_tab [SLOTS];
        logic [63:0] cmean_tab [SLOTS];
        logic [63:0] cdev_tab [SLOTS];
        logic [63:0] rmean_tab [SLOTS];
        logic [63:0] rdev_tab [SLOTS];
        logic [6:0]  cpeak_tab [SLOTS];
        logic [31:0] rpeak_tab [SLOTS];
        result_t     expected_q[$];
        int          errors;
        int          words;
        int          anomalies;
        int          full_hits;

        function new();
            sigma = SIGMA_RESET;
            min_count = MIN_SAMPLES_RESET;
            used = 0;
            errors = 0;
            words = 0;
            anomalies = 0;
            full_hits = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] data);
            if (idx == REG_SIGMA)
                sigma = data[7:0];
            else if (idx == REG_MIN_SAMPLES)
                min_count = data;
        endfunction

        function logic [63:0] isqrt(logic [127:0] v);
            logic [63:0]  r;
            logic [63:0]  cand;
            logic [127:0] sq;
            r = '0;
            for (int b = 63; b >= 0; b--) begin
                cand = r | (64'd1 << b);
                sq = {64'd0, cand} * {64'd0, cand};
                if (sq <= v)
                    r = cand;
            end
            return r;
        endfunction

        // one welford step in Q8, division truncates, deviation floors
        function void welford(logic [63:0] xq, inout logic [63:0] mean,
                              inout logic [63:0] dev, input logic [15:0] n);
            logic [127:0] d;
            logic [127:0] nm;
            logic [127:0] prod;
            logic [127:0] acc;
            if (xq >= mean) begin
                d = {64'd0, xq - mean};
                nm = {64'd0, mean} + d / n;
                prod = d * ({64'd0, xq} - nm);
            end
            else begin
                d = {64'd0, mean - xq};
                nm = {64'd0, mean} - d / n;
                prod = d * (nm - {64'd0, xq});
            end
            acc = {64'd0, dev} * {64'd0, dev} * (n - 1) + prod;
            dev = isqrt(acc / n);
            mean = nm[63:0];
        endfunction

        function bit over(logic [63:0] x, logic [63:0] mean, logic [63:0] dev);
            logic [63:0] lhs;
            logic [63:0] rhs;
            lhs = (x << FRAC) << 4;
            rhs = (mean << 4) + {56'd0, sigma} * dev;
            return lhs > rhs;
        endfunction

        function void note_word(item_t w);
            logic [6:0]  cpu;
            logic [63:0] cq;
            logic [63:0] rq;
            logic [63:0] m;
            logic [63:0] dv;
            logic [15:0] n;
            int          slot;
            bit          hit;
            result_t     r;
            cpu = (w.cpu > CPU_MAX) ? CPU_MAX : w.cpu;
            cq = {57'd0, cpu} << FRAC;
            rq = {32'd0, w.rss} << FRAC;
            hit = 0;
            slot = 0;
            for (int i = 0; i < used; i++)
                if (!hit && key_tab[i] == w.key) begin
                    hit = 1;
                    slot = i;
                end
            r = '0;
            if (w.upd) begin
                if (hit) begin
                    n = count_tab[slot];
                    if (n != COUNT_MAX)
                        n++;
                    count_tab[slot] = n;
                    m = cmean_tab[slot];
                    dv = cdev_tab[slot];
                    welford(cq, m, dv, n);
                    cmean_tab[slot] = m;
                    cdev_tab[slot] = dv;
                    m = rmean_tab[slot];
                    dv = rdev_tab[slot];
                    welford(rq, m, dv, n);
                    rmean_tab[slot] = m;
                    rdev_tab[slot] = dv;
                    if (cpu > cpeak_tab[slot])
                        cpeak_tab[slot] = cpu;
                    if (w.rss > rpeak_tab[slot])
                        rpeak_tab[slot] = w.rss;
                end
                else if (used < SLOTS) begin
                    slot = used;
                    used++;
                    hit = 1;
                    key_tab[slot] = w.key;
                    count_tab[slot] = 16'd1;
                    cmean_tab[slot] = cq;
                    cdev_tab[slot] = '0;
                    rmean_tab[slot] = rq;
                    rdev_tab[slot] = '0;
                    cpeak_tab[slot] = cpu;
                    rpeak_tab[slot] = w.rss;
                end
                else begin
                    r.full = 1'b1;
                    full_hits++;
                end
            end
            if (hit) begin
                r.found = 1'b1;
                if (count_tab[slot] >= min_count) begin
                    r.cpu_anom = over({57'd0, cpu}, cmean_tab[slot], cdev_tab[slot]);
                    r.rss_anom = over({32'd0, w.rss}, rmean_tab[slot], rdev_tab[slot]);
                end
                r.mean_cpu = cmean_tab[slot][MEAN_OUT_BITS-1:0];
                r.count = count_tab[slot];
                r.peak_cpu = cpeak_tab[slot];
                r.peak_rss = rpeak_tab[slot];
            end
            if (r.cpu_anom || r.rss_anom)
                anomalies++;
            words++;
            expected_q.push_back(r);
        endfunction

        function void field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t ns: %s mismatch, expected %0h, got %0h",
                         $realtime, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_word(result_t got);
            result_t e;
            if (expected_q.size() == 0) begin
                $display("%0t ns: unexpected result word, got %p", $realtime, got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            field("entry_found", e.found, got.found);
            field("table_full", e.full, got.full);
            field("cpu_anomaly", e.cpu_anom, got.cpu_anom);
            field("rss_anomaly", e.rss_anom, got.rss_anom);
            field("cpu_mean_q8", e.mean_cpu, got.mean_cpu);
            field("sample_count", e.count, got.count);
            field("peak_cpu", e.peak_cpu, got.peak_cpu);
            field("peak_rss", e.peak_rss, got.peak_rss);
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [MAX_KEY_BITS-1:0]   name_key;
    logic [CPU_BITS-1:0]       cpu_percent;
    logic [RSS_BITS-1:0]       rss_kilobytes;
    logic                      update_enable;
    logic                      done;
    logic                      entry_found;
    logic                      table_full;
    logic                      cpu_anomaly;
    logic                      rss_anomaly;
    logic [MEAN_OUT_BITS-1:0]  cpu_mean_q8;
    logic [COUNT_BITS-1:0]     sample_count;
    logic [CPU_BITS-1:0]       peak_cpu;
    logic [RSS_BITS-1:0]       peak_rss;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    stats_scoreboard sb = new();

    logic [63:0] pool_key [POOL];
    logic [6:0]  pool_cpu [POOL];
    logic [31:0] pool_rss [POOL];
    bit          steady;

    keyed_running_stats_anomaly dut (.*);

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #100_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_word('{entry_found, table_full, cpu_anomaly, rss_anomaly,
                            cpu_mean_q8, sample_count, peak_cpu, peak_rss});
    end

    function int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (steady || p < 50)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 300);
    endfunction

    // hold start across back-to-back words, lower it only for a gap
    task automatic send_word(logic [63:0] k, logic [6:0] c, logic [31:0] r, logic u);
        int g;
        start <= 1'b1;
        name_key <= k;
        cpu_percent <= c;
        rss_kilobytes <= r;
        update_enable <= u;
        do
            @(posedge clk);
        while (busy);
        sb.note_word('{k, c, r, u});
        if ($urandom_range(0, 199) == 0)
            steady = ~steady;
        g = gap_len();
        if (g > 0)
        begin
            start <= 1'b0;
            name_key <= {$urandom, $urandom};
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    // mostly samples near the key's usual level, now and then a spike
    task automatic random_word(int span);
        int          i;
        int          p;
        logic [6:0]  c;
        logic [31:0] r;
        i = $urandom_range(0, span - 1);
        p = $urandom_range(0, 99);
        if (p < 80)
        begin
            c = pool_cpu[i] + 7'($urandom_range(0, 6));
            r = pool_rss[i] + 32'($urandom_range(0, 4000));
        end
        else
        begin
            c = 7'($urandom);
            r = (p < 90) ? $urandom : pool_rss[i] << $urandom_range(1, 3);
        end
        send_word(pool_key[i], c, r, $urandom_range(0, 99) < 85);
    endtask

    initial
    begin
        start = 1'b0;
        name_key = '0;
        cpu_percent = '0;
        rss_kilobytes = '0;
        update_enable = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        steady = 0;
        rst_n = 1'b0;
        for (int i = 0; i < POOL; i++)
        begin
            pool_key[i] = {$urandom, $urandom};
            pool_cpu[i] = 7'($urandom_range(0, 90));
            pool_rss[i] = (i % 3 == 0) ? $urandom : $urandom_range(1000, 900000);
        end
        pool_key[0] = '0;
        pool_key[1] = '1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed: extremes, clamping, missing keys, check-only words
        send_word('1, 7'd0, 32'd0, 1'b0);
        send_word('0, 7'd0, 32'd0, 1'b1);
        send_word('0, 7'd127, 32'hFFFF_FFFF, 1'b1);
        send_word('0, 7'd101, 32'hFFFF_FFFF, 1'b1);
        send_word('1, 7'd100, 32'h8000_0000, 1'b1);
        for (int j = 0; j < 5; j++)
            send_word('1, 7'd10, 32'd5000, 1'b1);
        send_word('1, 7'd100, 32'hFFFF_FFFF, 1'b0);
        send_word('1, 7'd10, 32'd5000, 1'b0);
        send_word('0, 7'd0, 32'd0, 1'b0);
        send_word(64'h5555_AAAA_5555_AAAA, 7'd50, 32'd1, 1'b0);
        drain();

        write_reg(REG_SIGMA, 16'hFF00);
        write_reg(REG_MIN_SAMPLES, 16'd1);
        write_reg(REG_SPARE, 16'hFFFF);
        send_word('1, 7'd11, 32'd5001, 1'b0);
        repeat (480) random_word(24);
        drain();

        write_reg(REG_SIGMA, 16'h00FF);
        write_reg(REG_MIN_SAMPLES, 16'hFFFF);
        repeat (300) random_word(24);
        drain();

        write_reg(REG_SIGMA, 16'd16);
        write_reg(REG_MIN_SAMPLES, 16'd3);
        repeat (500) random_word(24);
        drain();

        // enough distinct keys to run the table out of slots
        write_reg(REG_SIGMA, 16'($urandom_range(8, 64)));
        write_reg(REG_MIN_SAMPLES, 16'($urandom_range(1, 8)));
        repeat (700) random_word(POOL);
        drain();
        repeat (200) @(posedge clk);

        $display("%0d words checked, %0d slots used, %0d anomaly results, %0d refused as full",
                 sb.words, sb.used, sb.anomalies, sb.full_hits);
        $display("covered both register extremes, clamped cpu, missing keys and a full table");
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

### filelist.f
+incdir+src
src/krsa_pkg.sv
src/krsa_front.sv
src/krsa_arith.sv
src/krsa_back.sv
src/keyed_running_stats_anomaly.sv
src/krsa_checker.sv
test/tb_keyed_running_stats_anomaly.sv
